FILE: design/btjs_pkg.sv
`timescale 1ns / 1ps
// btjs_pkg: shared types, constants, control-word layout and helpers for the
// bilateral teleoperation joint step block. No dependencies.
package btjs_pkg;

  localparam int JOINTS = 7;
  // Index width for the per-joint state; the joint field itself is 3 bits.
  localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [4:0] JOINTS_5 = 5'(JOINTS);
  // Joints that have an alpha byte in the packed alpha register.
  localparam logic [3:0] ALPHA_JOINTS = 4'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_RELATIVE_MAPPING = 3'd0;
  localparam logic [2:0] REG_POSITION_SCALE   = 3'd1;
  localparam logic [2:0] REG_MAX_JOINT_STEP   = 3'd2;
  localparam logic [2:0] REG_FEEDBACK_GAIN    = 3'd3;
  localparam logic [2:0] REG_ALPHA_PACK       = 3'd4;
  localparam logic [2:0] REG_PASSIVE_MODE     = 3'd5;
  localparam logic [2:0] REG_HAPTIC_ENABLE    = 3'd6;

  localparam int CFG_DATA_W = 56;

  // Multiplier operand selects.
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_POS  = 3'd1;  // position_scale * leader offset (or position)
  localparam logic [2:0] MUL_TAU  = 3'd2;  // feedback_gain * follower torque
  localparam logic [2:0] MUL_PWR  = 3'd3;  // leader_vel * tau
  localparam logic [2:0] MUL_MLO  = 3'd4;  // |power| low part * alpha
  localparam logic [2:0] MUL_MHI  = 3'd5;  // |power| high part * alpha

  // Result forms.
  localparam logic [2:0] RES_NONE = 3'd0;
  localparam logic [2:0] RES_UPD  = 3'd1;
  localparam logic [2:0] RES_GRAV = 3'd2;
  localparam logic [2:0] RES_CAP  = 3'd3;
  localparam logic [2:0] RES_OOR  = 3'd4;

  // Jump conditions.
  localparam logic [1:0] C_NEVER = 2'd0;
  localparam logic [1:0] C_BADJ  = 2'd1;
  localparam logic [1:0] C_CAPT  = 2'd2;
  localparam logic [1:0] C_GRAV  = 2'd3;

  typedef struct packed {
    logic              action;
    logic [2:0]        joint;
    logic signed [31:0] leader_pos;
    logic signed [31:0] leader_vel;
    logic signed [31:0] follower_pos;
    logic signed [31:0] follower_ext_torque;
  } sample_t;

  typedef struct packed {
    logic [2:0]         out_joint;
    logic signed [31:0] follower_target;
    logic signed [31:0] leader_torque;
    logic               drive_follower;
    logic               drive_leader;
  } result_t;

  typedef struct packed {
    logic               relative_mapping;
    logic signed [23:0] position_scale;
    logic [23:0]        max_joint_step;
    logic signed [23:0] feedback_gain;
    logic [55:0]        alpha_pack;
    logic               passive_mode;
    logic               haptic_enable;
  } cfg_t;

  // One microcode word.
  typedef struct packed {
    logic [2:0] mul;
    logic       load;
    logic       raw;
    logic       lim;
    logic       tau;
    logic       pwr;
    logic       macc_lo;
    logic       macc_hi;
    logic [2:0] res;
    logic [1:0] cond;
    logic [3:0] target;
    logic       done;
  } ctrl_t;

  // Datapath status seen by the sequencer's jump logic.
  typedef struct packed {
    logic bad_joint;
    logic capture;
    logic gravity;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v[50:31] != {20{v[50]}}) begin
      r = v[50] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: design/btjs_datapath.sv
`timescale 1ns / 1ps
// btjs_datapath: item register, per-joint state, shared multiplier and the
// registers stepped by the microcode word. Depends on btjs_pkg.
module btjs_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  btjs_pkg::sample_t sample,
  input  btjs_pkg::cfg_t    cfg,
  input  btjs_pkg::ctrl_t   ctrl,
  output btjs_pkg::stat_t   stat,
  output btjs_pkg::result_t res_next
);
  import btjs_pkg::*;

  sample_t it;
  logic [JIDX_W-1:0] jx;

  logic signed [31:0] lref_mem [JOINTS];
  logic signed [31:0] fref_mem [JOINTS];
  logic signed [31:0] prev_mem [JOINTS];
  logic [JOINTS-1:0]  vld;

  logic signed [31:0] lref, fref, base, raw, target, tau;
  logic               pneg;
  logic [46:0]        mag;
  logic [55:0]        macc;
  logic signed [64:0] prod;

  logic signed [32:0] ma;
  logic signed [31:0] mb;
  logic signed [64:0] ma_x, mb_x;
  logic [7:0]         alpha;
  logic signed [64:0] rsum;
  logic signed [48:0] rnd;
  logic signed [50:0] raw_sum;
  logic signed [32:0] d, limx, base_x, b_hi, b_lo;
  logic signed [31:0] tn;
  logic signed [64:0] pabs;
  logic [48:0]        m;
  logic signed [50:0] tq_sum;
  logic               vel_pos;

  assign jx = JIDX_W'(it.joint);

  assign stat.bad_joint = ({2'b00, it.joint} >= JOINTS_5);
  assign stat.capture   = it.action;
  assign stat.gravity   = cfg.passive_mode;

  always_comb begin
    alpha = 8'd0;
    for (int k = 0; k < 7; k++) begin
      if ({1'b0, it.joint} == 4'(k) && 4'(k) < ALPHA_JOINTS) begin
        alpha = cfg.alpha_pack[8*k +: 8];
      end
    end
  end

  // Shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (ctrl.mul)
      MUL_POS: begin
        ma = cfg.relative_mapping ?
             ({it.leader_pos[31], it.leader_pos} - {lref[31], lref}) :
             {it.leader_pos[31], it.leader_pos};
        mb = {{8{cfg.position_scale[23]}}, cfg.position_scale};
      end
      MUL_TAU: begin
        ma = {it.follower_ext_torque[31], it.follower_ext_torque};
        mb = {{8{cfg.feedback_gain[23]}}, cfg.feedback_gain};
      end
      MUL_PWR: begin
        ma = {it.leader_vel[31], it.leader_vel};
        mb = tau;
      end
      MUL_MLO: begin
        ma = {9'd0, mag[23:0]};
        mb = {24'd0, alpha};
      end
      MUL_MHI: begin
        ma = {10'd0, mag[46:24]};
        mb = {24'd0, alpha};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign ma_x = {{32{ma[32]}}, ma};
  assign mb_x = {{33{mb[31]}}, mb};

  // Round half up of a Q.16 product
  assign rsum = prod + 65'sd32768;
  assign rnd  = rsum[64:16];

  assign raw_sum = {{2{rnd[48]}}, rnd} +
                   (cfg.relative_mapping ? {{19{fref[31]}}, fref} : 51'sd0);

  // Step limit: clamp raw into base +/- max_joint_step, unless that is zero
  assign base_x = {base[31], base};
  assign d      = {raw[31], raw} - base_x;
  assign limx   = {9'd0, cfg.max_joint_step};
  assign b_hi   = base_x + limx;
  assign b_lo   = base_x - limx;
  always_comb begin
    if (cfg.max_joint_step == 24'd0) begin
      tn = raw;
    end else if (d > limx) begin
      tn = b_hi[31:0];
    end else if (d < -limx) begin
      tn = b_lo[31:0];
    end else begin
      tn = raw;
    end
  end

  assign pabs = prod[64] ? -prod : prod;

  // Passivity term and final torque
  assign vel_pos = !it.leader_vel[31] && (it.leader_vel != 32'sd0);
  assign m       = pneg ? macc[55:7] : 49'd0;
  assign tq_sum  = -{{19{tau[31]}}, tau} +
                   (vel_pos ? -$signed({2'b00, m}) : $signed({2'b00, m}));

  always_ff @(posedge clk) begin
    if (start) begin
      it <= sample;
    end
    prod <= ma_x * mb_x;
    if (ctrl.load) begin
      lref <= vld[jx] ? lref_mem[jx] : it.leader_pos;
      fref <= vld[jx] ? fref_mem[jx] : it.follower_pos;
      base <= vld[jx] ? prev_mem[jx] : it.follower_pos;
    end
    if (ctrl.raw) begin
      raw <= sat32(raw_sum);
    end
    if (ctrl.lim) begin
      target <= tn;
    end
    if (ctrl.tau) begin
      tau <= sat32({{2{rnd[48]}}, rnd});
    end
    if (ctrl.pwr) begin
      pneg <= prod[64];
      mag  <= pabs[62:16];
    end
    if (ctrl.macc_lo) begin
      macc <= {23'd0, prod[32:0]};
    end else if (ctrl.macc_hi) begin
      macc <= macc + {prod[31:0], 24'd0};
    end
  end

  // Per-joint state
  always_ff @(posedge clk) begin
    if (ctrl.lim) begin
      lref_mem[jx] <= lref;
      fref_mem[jx] <= fref;
      prev_mem[jx] <= tn;
    end else if (ctrl.res == RES_CAP) begin
      lref_mem[jx] <= it.leader_pos;
      fref_mem[jx] <= it.follower_pos;
      prev_mem[jx] <= it.follower_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctrl.lim || ctrl.res == RES_CAP) begin
      vld[jx] <= 1'b1;
    end
  end

  always_comb begin
    res_next = '0;
    res_next.out_joint = it.joint;
    case (ctrl.res)
      RES_UPD: begin
        res_next.follower_target = target;
        res_next.leader_torque   = sat32(tq_sum);
        res_next.drive_follower  = 1'b1;
        res_next.drive_leader    = cfg.haptic_enable;
      end
      RES_GRAV: begin
        res_next.follower_target = target;
      end
      RES_CAP: begin
        res_next.follower_target = it.follower_pos;
      end
      default: begin
        res_next.follower_target = 32'sd0;
      end
    endcase
  end

endmodule

FILE: design/btjs_sequencer.sv
`timescale 1ns / 1ps
// btjs_sequencer: step counter, microcode table and conditional jumps.
// Depends on btjs_pkg.
module btjs_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            slot_free,
  input  btjs_pkg::stat_t stat,
  output btjs_pkg::ctrl_t ctrl,
  output logic            busy,
  output logic            finish
);
  import btjs_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_POS   = 4'd1;
  localparam logic [3:0] S_RAW   = 4'd2;
  localparam logic [3:0] S_LIM   = 4'd3;
  localparam logic [3:0] S_PMUL  = 4'd4;
  localparam logic [3:0] S_PABS  = 4'd5;
  localparam logic [3:0] S_MLO   = 4'd6;
  localparam logic [3:0] S_MHI   = 4'd7;
  localparam logic [3:0] S_MACC  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_GRAV  = 4'd10;
  localparam logic [3:0] S_CAP   = 4'd11;
  localparam logic [3:0] S_OOR   = 4'd12;

  logic       running;
  logic [3:0] pc;
  ctrl_t      rom;
  logic       taken;

  // Program
  always_comb begin
    rom = '0;
    case (pc)
      S_LOAD: begin
        rom.load = 1'b1;  rom.cond = C_BADJ;  rom.target = S_OOR;
      end
      S_POS: begin
        rom.mul = MUL_POS;  rom.cond = C_CAPT;  rom.target = S_CAP;
      end
      S_RAW: begin
        rom.raw = 1'b1;  rom.mul = MUL_TAU;
      end
      S_LIM: begin
        rom.lim = 1'b1;  rom.tau = 1'b1;  rom.cond = C_GRAV;  rom.target = S_GRAV;
      end
      S_PMUL: rom.mul = MUL_PWR;
      S_PABS: rom.pwr = 1'b1;
      S_MLO:  rom.mul = MUL_MLO;
      S_MHI: begin
        rom.mul = MUL_MHI;  rom.macc_lo = 1'b1;
      end
      S_MACC: rom.macc_hi = 1'b1;
      S_FIN: begin
        rom.res = RES_UPD;  rom.done = 1'b1;
      end
      S_GRAV: begin
        rom.res = RES_GRAV;  rom.done = 1'b1;
      end
      S_CAP: begin
        rom.res = RES_CAP;  rom.done = 1'b1;
      end
      S_OOR: begin
        rom.res = RES_OOR;  rom.done = 1'b1;
      end
      default: rom = '0;
    endcase
  end

  assign ctrl = running ? rom : '0;

  always_comb begin
    case (rom.cond)
      C_BADJ:  taken = stat.bad_joint;
      C_CAPT:  taken = stat.capture;
      C_GRAV:  taken = stat.gravity;
      default: taken = 1'b0;
    endcase
  end

  assign busy   = running;
  assign finish = running && rom.done && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= S_LOAD;
    end else if (start) begin
      running <= 1'b1;
      pc      <= S_LOAD;
    end else if (running) begin
      if (rom.done) begin
        if (slot_free) begin
          running <= 1'b0;
        end
      end else if (taken) begin
        pc <= rom.target;
      end else begin
        pc <= pc + 4'd1;
      end
    end
  end

endmodule

FILE: design/bilateral_teleop_joint_step.sv
`timescale 1ns / 1ps
// bilateral_teleop_joint_step: top level with configuration registers,
// handshakes and result register. Depends on btjs_pkg, btjs_sequencer and
// btjs_datapath.
//
// One sample item per joint goes in, one result item comes out. A short
// microprogram runs each item through one shared 33x32 signed multiplier
// that is used at most once per step. An update chains five products
// (scaled position, torque gain, leader power, two partial products of the
// passivity term); a gravity-only update ends after the torque gain, a
// reference capture after the scaled position, an out-of-range joint after
// the load step. The next item is accepted in the cycle after the result is
// registered, so no new item is taken while one is in flight. A finished
// result waits in the output register; if it has not been taken when the
// next one completes, the program holds on its last step. Per-joint
// references and previous targets live in small register files; a valid bit
// per joint, cleared by reset, marks joints that have no reference yet, and
// the first update of such a joint latches both references from the sample.
// Configuration writes are meant for idle periods only.
module bilateral_teleop_joint_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  btjs_pkg::sample_t  sample,
  output logic               result_valid,
  input  logic               result_ready,
  output btjs_pkg::result_t  result,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [btjs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import btjs_pkg::*;

  cfg_t    cfg;
  ctrl_t   ctrl;
  stat_t   stat;
  result_t res_next;
  logic    busy;
  logic    finish;
  logic    start;
  logic    slot_free;

  // Configuration registers, reset to their documented defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.relative_mapping <= 1'b1;
      cfg.position_scale   <= 24'sd65536;
      cfg.max_joint_step   <= 24'd0;
      cfg.feedback_gain    <= 24'sd65536;
      cfg.alpha_pack       <= 56'd0;
      cfg.passive_mode     <= 1'b0;
      cfg.haptic_enable    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RELATIVE_MAPPING: cfg.relative_mapping <= cfg_data[0];
        REG_POSITION_SCALE:   cfg.position_scale   <= cfg_data[23:0];
        REG_MAX_JOINT_STEP:   cfg.max_joint_step   <= cfg_data[23:0];
        REG_FEEDBACK_GAIN:    cfg.feedback_gain    <= cfg_data[23:0];
        REG_ALPHA_PACK:       cfg.alpha_pack       <= cfg_data[55:0];
        REG_PASSIVE_MODE:     cfg.passive_mode     <= cfg_data[0];
        REG_HAPTIC_ENABLE:    cfg.haptic_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // One item in flight; the output register decouples the result side.
  assign sample_ready = !busy;
  assign start        = sample_valid && sample_ready;
  assign slot_free    = !result_valid || result_ready;

  btjs_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .slot_free (slot_free),
    .stat      (stat),
    .ctrl      (ctrl),
    .busy      (busy),
    .finish    (finish)
  );

  btjs_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .sample   (sample),
    .cfg      (cfg),
    .ctrl     (ctrl),
    .stat     (stat),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result <= res_next;
    end
  end

  // A new result only appears after the program finished an item.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(finish))
    else $error("result appeared without a finished item");

  // The program never finishes unless an item is in flight.
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    finish |-> busy)
    else $error("finish while idle");

  // The leader is never driven without the follower.
  a_drive_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.drive_leader || result.drive_follower))
    else $error("leader drive without follower drive");

  // Out-of-range joints give an all-zero result.
  a_bad_joint_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ({2'b00, result.out_joint} >= JOINTS_5)) |->
    (result.follower_target == 32'sd0 && result.leader_torque == 32'sd0 &&
     !result.drive_follower))
    else $error("out-of-range joint produced a nonzero result");

endmodule

FILE: verif/tb_bilateral_teleop_joint_step.sv
`timescale 1ns / 1ps
// tb_bilateral_teleop_joint_step: self-checking bench for the bilateral
// teleoperation joint step block. Depends on btjs_pkg and
// bilateral_teleop_joint_step.
module tb_bilateral_teleop_joint_step;
  import btjs_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int SETTLE_CYCLES   = 14;     // idle margin after the last result returns
  localparam int HOLDOFF_CYCLES  = 400;    // long receiver hold-off, fills the block
  localparam int CYCLE_LIMIT     = 600000;

  // Scoreboard: shadow copy of the per-joint state and the configuration,
  // predicts one result per accepted item and checks results in order.
  class teleop_scoreboard;
    cfg_t    cfg;
    int      leader_ref[JOINTS];
    int      follower_ref[JOINTS];
    int      last_target[JOINTS];
    bit      ref_latched[JOINTS];
    result_t expected_results[$];
    int      errors;

    function new();
      cfg = '0;
      cfg.relative_mapping = 1'b1;
      cfg.position_scale   = 24'sd65536;
      cfg.feedback_gain    = 24'sd65536;
      cfg.haptic_enable    = 1'b1;
      errors = 0;
    endfunction

    function void set_config(cfg_t c);
      cfg = c;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    static function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Q-format product back to 16 fractional bits, rounding half up.
    static function longint round16(longint v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function result_t predict_joint_result(sample_t s);
      result_t      r;
      longint       lp, lv, fp, ft, scale, gain;
      longint       base, raw, step, lim, target, tau, pwr, trq, mag, m;
      int unsigned  j;
      logic [7:0]   alpha;
      r = '0;
      r.out_joint = s.joint;
      j = 32'(s.joint);
      if (j >= JOINTS) return r;   // joint out of range: zero result, no state change
      lp = longint'($signed(s.leader_pos));
      lv = longint'($signed(s.leader_vel));
      fp = longint'($signed(s.follower_pos));
      ft = longint'($signed(s.follower_ext_torque));
      if (s.action) begin
        // reference capture
        leader_ref[j]   = s.leader_pos;
        follower_ref[j] = s.follower_pos;
        last_target[j]  = s.follower_pos;
        ref_latched[j]  = 1'b1;
        r.follower_target = s.follower_pos;
        return r;
      end
      if (!ref_latched[j]) begin
        // first update of a joint latches both references from the sample
        leader_ref[j]   = s.leader_pos;
        follower_ref[j] = s.follower_pos;
        base = fp;
      end else begin
        base = longint'(last_target[j]);
      end
      scale = longint'($signed(cfg.position_scale));
      if (cfg.relative_mapping)
        raw = longint'(follower_ref[j]) + round16(scale * (lp - longint'(leader_ref[j])));
      else
        raw = round16(scale * lp);
      raw = clamp32(raw);
      if (cfg.max_joint_step != 0) begin
        lim  = longint'(cfg.max_joint_step);
        step = raw - base;
        if (step > lim) step = lim;
        if (step < -lim) step = -lim;
        target = base + step;
      end else begin
        target = raw;
      end
      last_target[j] = int'(target);
      ref_latched[j] = 1'b1;
      r.follower_target = target[31:0];
      if (!cfg.passive_mode) begin
        gain = longint'($signed(cfg.feedback_gain));
        tau  = clamp32(round16(gain * ft));
        pwr  = lv * tau;
        trq  = -tau;
        if (pwr < 0) begin
          // passivity term opposes leader motion, scaled by the joint's alpha
          alpha = cfg.alpha_pack[8*j +: 8];
          mag   = (-pwr) >>> 16;
          m     = (mag * longint'(alpha)) >>> 7;
          trq   = (lv > 0) ? trq - m : trq + m;
        end
        r.leader_torque  = clamp32(trq);
        r.drive_follower = 1'b1;
        r.drive_leader   = cfg.haptic_enable;
      end
      return r;
    endfunction

    function void note_sample(sample_t s);
      expected_results.push_back(predict_joint_result(s));
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      end
    endfunction

    function void check_result(result_t r);
      result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        $error("result item with nothing expected: joint %0d", r.out_joint);
        return;
      end
      e = expected_results.pop_front();
      compare_field("out_joint", e.out_joint, r.out_joint);
      compare_field("follower_target", $signed(e.follower_target), $signed(r.follower_target));
      compare_field("leader_torque", $signed(e.leader_torque), $signed(r.leader_torque));
      compare_field("drive_follower", e.drive_follower, r.drive_follower);
      compare_field("drive_leader", e.drive_leader, r.drive_leader);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  sample_t               sample_data = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result_data;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_index = REG_RELATIVE_MAPPING;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  teleop_scoreboard board;
  int send_idle_pct  = 0;   // chance per cycle that the sender sits out
  int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  int holdoff_req    = 0;   // set by the stimulus, consumed by the receiver
  int holdoff_left   = 0;
  int cycle_count    = 0;

  bilateral_teleop_joint_step i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: checks every accepted result item, then decides ready for the
  // next edge. A hold-off request forces ready low for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) board.check_result(result_data);
      if (holdoff_req > 0) begin
        holdoff_left = holdoff_req;
        holdoff_req  = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic sample_t mk(bit act, bit [2:0] j, int lp, int lv, int fp, int ft);
    sample_t s;
    s.action              = act;
    s.joint               = j;
    s.leader_pos          = lp;
    s.leader_vel          = lv;
    s.follower_pos        = fp;
    s.follower_ext_torque = ft;
    return s;
  endfunction

  // Mostly plausible magnitudes (within +/- 2^(bits-1)), sometimes any pattern.
  function automatic int rand_q(int bits);
    if ($urandom_range(99) < 70)
      return int'($urandom_range((1 << bits) - 1)) - (1 << (bits - 1));
    return $urandom;
  endfunction

  function automatic sample_t make_item();
    bit [2:0] j;
    j = ($urandom_range(99) < 6) ? 3'd7 : 3'($urandom_range(JOINTS - 1));
    return mk($urandom_range(99) < 12, j, rand_q(27), rand_q(19), rand_q(27), rand_q(23));
  endfunction

  function automatic logic [23:0] rand_gain();
    case ($urandom_range(3))
      0:       return 24'd65536;
      1:       return 24'($urandom);
      2:       return 24'(rand_q(18));
      default: return 24'hFF0000;   // -1.0
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.relative_mapping = 1'($urandom_range(1));
    c.position_scale   = rand_gain();
    c.feedback_gain    = rand_gain();
    case ($urandom_range(2))
      0:       c.max_joint_step = '0;
      1:       c.max_joint_step = 24'($urandom_range(1 << 20));
      default: c.max_joint_step = 24'($urandom);
    endcase
    c.alpha_pack    = 56'({$urandom, $urandom});
    c.passive_mode  = ($urandom_range(4) == 0);
    c.haptic_enable = 1'($urandom_range(1));
    return c;
  endfunction

  // Offers one item and returns at the edge that accepts it, valid still high
  // so that a back-to-back item keeps valid up without a glitch.
  task automatic send_sample(sample_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_data  <= s;
    do @(posedge clk); while (!sample_ready);
    board.note_sample(s);
  endtask

  task automatic withdraw_sample();
    sample_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Block goes idle: nothing offered, every expected item back, pipeline flushed.
  task automatic drain_results();
    withdraw_sample();
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes all seven registers back to back while idle.
  task automatic apply_cfg(cfg_t c);
    drain_results();
    write_reg(REG_RELATIVE_MAPPING, {55'd0, c.relative_mapping});
    write_reg(REG_POSITION_SCALE,   {32'd0, c.position_scale});
    write_reg(REG_MAX_JOINT_STEP,   {32'd0, c.max_joint_step});
    write_reg(REG_FEEDBACK_GAIN,    {32'd0, c.feedback_gain});
    write_reg(REG_ALPHA_PACK,       c.alpha_pack);
    write_reg(REG_PASSIVE_MODE,     {55'd0, c.passive_mode});
    write_reg(REG_HAPTIC_ENABLE,    {55'd0, c.haptic_enable});
    cfg_we <= 1'b0;
    @(posedge clk);
    board.set_config(c);
  endtask

  initial begin
    cfg_t c;
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset configuration: relative mapping, unity gains, no limit.
    send_sample(mk(0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000)); // no ref yet
    send_sample(mk(0, 0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff)); // widest offset
    send_sample(mk(1, 1, 32'h01000000, 32'h0, 32'hff000000, 32'h0));               // capture
    send_sample(mk(0, 1, 32'h01800000, 32'h00010000, 32'h0, 32'h00020000));
    send_sample(mk(0, 7, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff)); // bad joint
    send_sample(mk(1, 7, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
    send_sample(mk(0, 2, 32'h0, 32'h0, 32'h0, 32'h0));

    // Absolute mapping, extreme scale and gain, step limit, full alphas, haptic off.
    c = '0;
    c.position_scale = 24'h800000;
    c.max_joint_step = 24'h100000;
    c.feedback_gain  = 24'h7fffff;
    c.alpha_pack     = '1;
    apply_cfg(c);
    send_sample(mk(0, 3, 32'h02000000, 32'h7fffffff, 32'h00100000, 32'h80000000)); // limit from follower
    send_sample(mk(0, 3, 32'hfe000000, 32'h80000000, 32'h0, 32'h7fffffff));        // negative power
    send_sample(mk(0, 4, 32'h00010000, 32'h0, 32'h0, 32'h00010000));               // zero velocity
    send_sample(mk(0, 4, 32'h00000001, 32'hffffffff, 32'h0, 32'h00000001));

    // Gravity-only mode with the other extremes.
    c = '0;
    c.relative_mapping = 1'b1;
    c.position_scale   = 24'h7fffff;
    c.max_joint_step   = 24'hffffff;
    c.feedback_gain    = 24'h800000;
    c.alpha_pack       = 56'h80402010080402;
    c.passive_mode     = 1'b1;
    c.haptic_enable    = 1'b1;
    apply_cfg(c);
    send_sample(mk(0, 5, 32'h00400000, 32'h00020000, 32'h00100000, 32'h00030000));
    send_sample(mk(1, 5, 32'h00200000, 32'h00020000, 32'hfff00000, 32'h00030000));
    send_sample(mk(0, 6, 32'hffc00000, 32'hfffe0000, 32'h00800000, 32'hfffd0000));
    send_sample(mk(0, 5, 32'h00300000, 32'h00010000, 32'h0, 32'h0));

    // Zero scale and gain, step limit of one LSB.
    c = '0;
    c.relative_mapping = 1'b1;
    c.max_joint_step   = 24'd1;
    c.haptic_enable    = 1'b1;
    apply_cfg(c);
    send_sample(mk(0, 6, 32'h01000000, 32'h00010000, 32'h0, 32'h00010000));
    send_sample(mk(0, 0, 32'h01000000, 32'hffff0000, 32'h0, 32'h00010000));

    // Random phases; idling mode cycles through none, sender, receiver, both.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          c = '0;
          c.relative_mapping = 1'b1;
          c.position_scale   = 24'd65536;
          c.max_joint_step   = 24'h040000;
          c.feedback_gain    = 24'd65536;
          c.alpha_pack       = '1;
          c.haptic_enable    = 1'b1;
        end
        1: begin
          c = '0;
          c.position_scale = 24'hff0000;
          c.feedback_gain  = 24'h7fffff;
          c.alpha_pack     = 56'({$urandom, $urandom});
        end
        2: begin
          c = rand_cfg();
          c.passive_mode = 1'b1;
        end
        default: c = rand_cfg();
      endcase
      apply_cfg(c);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      // Back-pressure phase: receiver holds off while items keep coming.
      if (p == 4) holdoff_req = HOLDOFF_CYCLES;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 4 && n == ITEMS_PER_PHASE / 2) begin
          // sender pauses until every outstanding result is back
          withdraw_sample();
          while (board.pending() != 0) @(posedge clk);
        end
        send_sample(make_item());
      end
    end

    drain_results();
    if (board.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
